/* rtl/core/aabb_pkg.sv */
package aabb_pkg;

    // Coordinate and coefficient formats
    localparam int COORD_W   = 32;
    localparam int COEF_FRAC = 16;
    localparam int COEF_W    = COEF_FRAC + 4;
    localparam int ROW_W     = 3 * COEF_W;

    // Datapath widths: s = hi + lo, d = hi - lo (never negative once merged)
    localparam int SUM_W = COORD_W + 1;
    localparam int DIF_W = COORD_W;
    localparam int PS_W  = COEF_W + SUM_W;
    localparam int PD_W  = COEF_W + DIF_W;
    localparam int A_W   = PS_W + 2;
    localparam int B_W   = PD_W + 2;
    // B_W + 1 == A_W, so one more bit holds both A - B and A + B
    localparam int R_W   = A_W + 1;
    localparam int SH    = COEF_FRAC + 1;
    localparam int Q_W   = R_W - SH;
    localparam int V_W   = Q_W + 1;

    // Configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int REG_W  = ADDR_W - 3;

    localparam logic [REG_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [REG_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [REG_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [REG_W-1:0] REG_OFF_X = 3'd3;
    localparam logic [REG_W-1:0] REG_OFF_Y = 3'd4;
    localparam logic [REG_W-1:0] REG_OFF_Z = 3'd5;

    // Identity matrix at reset
    localparam logic [ROW_W-1:0] ROW_X_INIT = ROW_W'(1) << COEF_FRAC;
    localparam logic [ROW_W-1:0] ROW_Y_INIT = ROW_W'(1) << (COEF_FRAC + COEF_W);
    localparam logic [ROW_W-1:0] ROW_Z_INIT = ROW_W'(1) << (COEF_FRAC + 2 * COEF_W);

    localparam logic [COORD_W-1:0] COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};
    // empty box: low at the top, high at minus the top
    localparam logic [COORD_W-1:0] BOX_HI_INIT = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      final_point;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_min_x;
        logic signed [COORD_W-1:0] out_min_y;
        logic signed [COORD_W-1:0] out_min_z;
        logic signed [COORD_W-1:0] out_max_x;
        logic signed [COORD_W-1:0] out_max_y;
        logic signed [COORD_W-1:0] out_max_z;
        logic                      saturated_flag;
    } t_out_beat;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]   row;
        logic [2:0][COORD_W-1:0] offset;
    } t_cfg;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] s;
        logic [2:0][DIF_W-1:0] d;
    } t_sd;

endpackage

/* rtl/core/aabb_cfg.sv */
module aabb_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aabb_pkg::ADDR_W-1:0] paddr,
    input  logic [aabb_pkg::DATA_W-1:0] pwdata,
    output logic [aabb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output aabb_pkg::t_cfg             o_cfg
);
    import aabb_pkg::*;

    logic [ROW_W-1:0]   r_row [3];
    logic [COORD_W-1:0] r_off [3];
    logic               wr_en;
    logic [REG_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_X_INIT;
            r_row[1] <= ROW_Y_INIT;
            r_row[2] <= ROW_Z_INIT;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROW_X: r_row[0] <= pwdata[ROW_W-1:0];
                REG_ROW_Y: r_row[1] <= pwdata[ROW_W-1:0];
                REG_ROW_Z: r_row[2] <= pwdata[ROW_W-1:0];
                REG_OFF_X: r_off[0] <= pwdata[COORD_W-1:0];
                REG_OFF_Y: r_off[1] <= pwdata[COORD_W-1:0];
                REG_OFF_Z: r_off[2] <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_X: prdata = DATA_W'(r_row[0]);
            REG_ROW_Y: prdata = DATA_W'(r_row[1]);
            REG_ROW_Z: prdata = DATA_W'(r_row[2]);
            REG_OFF_X: prdata = DATA_W'(r_off[0]);
            REG_OFF_Y: prdata = DATA_W'(r_off[1]);
            REG_OFF_Z: prdata = DATA_W'(r_off[2]);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_cfg.row[i]    = r_row[i];
            o_cfg.offset[i] = r_off[i];
        end
    end

endmodule

/* rtl/core/aabb_box.sv */
module aabb_box (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  aabb_pkg::t_in_beat i_in,
    output logic               o_in_stall,
    output logic               o_sd_valid,
    output aabb_pkg::t_sd      o_sd,
    input  logic               i_sd_stall
);
    import aabb_pkg::*;

    t_in_beat                  r_in;
    logic                      r_in_vld;
    logic signed [COORD_W-1:0] r_lo [3];
    logic signed [COORD_W-1:0] r_hi [3];
    t_sd                       r_sd;
    logic                      r_sd_vld;

    logic signed [COORD_W-1:0] pos  [3];
    logic signed [COORD_W-1:0] m_lo [3];
    logic signed [COORD_W-1:0] m_hi [3];
    logic signed [SUM_W-1:0]   dif  [3];
    t_sd                       n_sd;
    logic                      sd_free;
    logic                      go;
    logic                      load_in;

    // s/d slot is free when empty or drained downstream this cycle
    assign sd_free    = !r_sd_vld || !i_sd_stall;
    assign go         = !r_in.final_point || sd_free;
    assign load_in    = !r_in_vld || go;
    assign o_in_stall = !load_in;
    assign o_sd_valid = r_sd_vld;
    assign o_sd       = r_sd;

    always_comb begin
        pos[0] = r_in.pos_x;
        pos[1] = r_in.pos_y;
        pos[2] = r_in.pos_z;
        for (int k = 0; k < 3; k++) begin
            m_lo[k]    = (pos[k] < r_lo[k]) ? pos[k] : r_lo[k];
            m_hi[k]    = (r_hi[k] < pos[k]) ? pos[k] : r_hi[k];
            n_sd.s[k]  = SUM_W'(m_hi[k]) + SUM_W'(m_lo[k]);
            dif[k]     = SUM_W'(m_hi[k]) - SUM_W'(m_lo[k]);
            n_sd.d[k]  = dif[k][DIF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_sd_vld <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= COORD_MAX;
                r_hi[k] <= BOX_HI_INIT;
            end
        end else begin
            if (load_in) begin
                r_in_vld <= i_in_valid;
            end
            if (sd_free) begin
                r_sd_vld <= r_in_vld && r_in.final_point;
            end
            if (r_in_vld && go) begin
                for (int k = 0; k < 3; k++) begin
                    // last point of a set leaves the box empty again
                    r_lo[k] <= r_in.final_point ? COORD_MAX   : m_lo[k];
                    r_hi[k] <= r_in.final_point ? BOX_HI_INIT : m_hi[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in <= i_in;
        end
        if (sd_free) begin
            r_sd <= n_sd;
        end
    end

endmodule

/* rtl/core/aabb_xform.sv */
module aabb_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aabb_pkg::t_cfg      i_cfg,
    input  logic                i_sd_valid,
    input  aabb_pkg::t_sd       i_sd,
    output logic                o_sd_stall,
    output logic                o_out_valid,
    output aabb_pkg::t_out_beat o_out,
    input  logic                i_out_stall
);
    import aabb_pkg::*;

    localparam logic signed [A_W-1:0] ROUND_HALF = A_W'(1) << COEF_FRAC;
    // output range is symmetric: +-COORD_MAX
    localparam logic signed [V_W-1:0] V_TOP      = V_W'(COORD_MAX);
    localparam logic signed [V_W-1:0] V_BOT      = -V_TOP;

    // products
    logic signed [PS_W-1:0] r_ps [3][3];
    logic        [PD_W-1:0] r_pd [3][3];
    logic                   r_p_vld;
    // per-axis sums, rounding term already in A
    logic signed [A_W-1:0]  r_a [3];
    logic        [B_W-1:0]  r_b [3];
    logic                   r_ab_vld;
    t_out_beat              r_out;
    logic                   r_out_vld;

    logic                   free_out;
    logic                   free_ab;
    logic                   free_p;

    logic signed [PS_W-1:0] n_ps [3][3];
    logic        [PD_W-1:0] n_pd [3][3];
    logic signed [A_W-1:0]  n_a  [3];
    logic        [B_W-1:0]  n_b  [3];
    logic signed [COEF_W-1:0] coef;
    logic        [COEF_W-1:0] coef_abs;

    logic signed [R_W-1:0]  ax;
    logic signed [R_W-1:0]  bx;
    logic signed [R_W-1:0]  rr;
    logic signed [V_W-1:0]  off;
    logic signed [V_W-1:0]  v;
    logic [COORD_W-1:0]     res [2][3];
    logic                   n_sat;
    t_out_beat              n_out;

    assign free_out    = !r_out_vld || !i_out_stall;
    assign free_ab     = !r_ab_vld || free_out;
    assign free_p      = !r_p_vld || free_ab;
    assign o_sd_stall  = !free_p;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef       = signed'(i_cfg.row[i][COEF_W*j +: COEF_W]);
                coef_abs   = coef[COEF_W-1] ? (~coef + 1'b1) : coef;
                n_ps[i][j] = coef * signed'(i_sd.s[j]);
                n_pd[i][j] = coef_abs * i_sd.d[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = A_W'(r_ps[i][0]) + A_W'(r_ps[i][1]) + A_W'(r_ps[i][2]) + ROUND_HALF;
            n_b[i] = B_W'(r_pd[i][0]) + B_W'(r_pd[i][1]) + B_W'(r_pd[i][2]);
        end
    end

    // res[0] is A - B (minimum), res[1] is A + B (maximum)
    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ax  = R_W'(r_a[i]);
            bx  = signed'(R_W'(r_b[i]));
            off = V_W'(signed'(i_cfg.offset[i]));
            for (int k = 0; k < 2; k++) begin
                rr = (k == 0) ? (ax - bx) : (ax + bx);
                v  = V_W'(signed'(rr[R_W-1:SH])) + off;
                if (v < V_BOT) begin
                    res[k][i] = V_BOT[COORD_W-1:0];
                    n_sat     = 1'b1;
                end else if (v > V_TOP) begin
                    res[k][i] = V_TOP[COORD_W-1:0];
                    n_sat     = 1'b1;
                end else begin
                    res[k][i] = v[COORD_W-1:0];
                end
            end
        end
        n_out.out_min_x      = res[0][0];
        n_out.out_min_y      = res[0][1];
        n_out.out_min_z      = res[0][2];
        n_out.out_max_x      = res[1][0];
        n_out.out_max_y      = res[1][1];
        n_out.out_max_z      = res[1][2];
        n_out.saturated_flag = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_ab_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (free_p) begin
                r_p_vld <= i_sd_valid;
            end
            if (free_ab) begin
                r_ab_vld <= r_p_vld;
            end
            if (free_out) begin
                r_out_vld <= r_ab_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_p) begin
            r_ps <= n_ps;
            r_pd <= n_pd;
        end
        if (free_ab) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (free_out) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/core/aabb_accumulate_transform.sv */
// Channel  Dir  Handshake                  Beat
// in       in   i_in_valid / o_in_stall    t_in_beat: one point and its last-point mark
// out      out  o_out_valid / i_out_stall  t_out_beat: transformed box and clamp flag
// cfg      in   APB psel/penable/pwrite    six registers at 8-byte spacing
//
// One point is taken every cycle while o_in_stall is low; the box compare-select loop updates once per beat.
// A last point raises o_out_valid once its result has passed the input, s/d,
// products, sums and output registers, and its result beat then goes out.
// Other points give no beat.
// Reset leaves the box empty and the matrix at identity.
// Each stage loads when empty or when the stage after it moves, so an output
// stall only holds back input once the result pipeline behind it is full.
module aabb_accumulate_transform (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  aabb_pkg::t_in_beat          i_in,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output aabb_pkg::t_out_beat         o_out,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aabb_pkg::ADDR_W-1:0] paddr,
    input  logic [aabb_pkg::DATA_W-1:0] pwdata,
    output logic [aabb_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import aabb_pkg::*;

    t_cfg cfg;
    t_sd  sd;
    logic sd_valid;
    logic sd_stall;

    aabb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aabb_box u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_sd_valid (sd_valid),
        .o_sd       (sd),
        .i_sd_stall (sd_stall)
    );

    aabb_xform u_xform (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_sd_valid  (sd_valid),
        .i_sd        (sd),
        .o_sd_stall  (sd_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

/* tb/sv/aabb_transform_checker.sv */
module aabb_transform_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  aabb_pkg::t_in_beat          i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  aabb_pkg::t_out_beat         i_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [aabb_pkg::ADDR_W-1:0] paddr,
    input  logic [aabb_pkg::DATA_W-1:0] pwdata,
    output int                          o_pending,
    output int                          o_fail_count
);
    import aabb_pkg::*;

    localparam longint COORD_TOP = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_BOT = -COORD_TOP;

    logic [ROW_W-1:0]          row_cfg [3];
    logic signed [COORD_W-1:0] off_cfg [3];
    logic signed [COORD_W-1:0] box_lo  [3];
    logic signed [COORD_W-1:0] box_hi  [3];
    t_out_beat                 box_q   [$];
    int                        errors = 0;

    function automatic void clear_box();
        for (int j = 0; j < 3; j++) begin
            box_lo[j] = COORD_MAX;
            box_hi[j] = BOX_HI_INIT;
        end
    endfunction

    // Grow the box by one point; on the last point of a set, work out the
    // transformed box (center M*c + t, half-extent |M|*e) and empty the box.
    function automatic bit absorb_point(input t_in_beat p, output t_out_beat res);
        logic signed [COORD_W-1:0] pos [3];
        logic signed [COORD_W-1:0] lo_out [3];
        logic signed [COORD_W-1:0] hi_out [3];
        logic signed [COEF_W-1:0]  coef;
        longint                    s [3];
        longint                    d [3];
        longint                    a, b, c, v;
        logic                      sat;
        pos[0] = p.pos_x;
        pos[1] = p.pos_y;
        pos[2] = p.pos_z;
        res = '0;
        for (int j = 0; j < 3; j++) begin
            if (pos[j] < box_lo[j]) box_lo[j] = pos[j];
            if (pos[j] > box_hi[j]) box_hi[j] = pos[j];
        end
        if (!p.final_point) return 1'b0;
        sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            s[j] = longint'(box_hi[j]) + longint'(box_lo[j]);
            d[j] = longint'(box_hi[j]) - longint'(box_lo[j]);
        end
        for (int i = 0; i < 3; i++) begin
            a = 0;
            b = 0;
            for (int j = 0; j < 3; j++) begin
                coef = row_cfg[i][j*COEF_W +: COEF_W];
                c = longint'(coef);
                a += c * s[j];
                b += ((c < 0) ? -c : c) * d[j];
            end
            for (int k = 0; k < 2; k++) begin
                // s and d are twice center and half-extent: drop one more bit,
                // rounding half up
                v = (((k == 0) ? a - b : a + b) + (longint'(1) <<< COEF_FRAC))
                    >>> (COEF_FRAC + 1);
                v += longint'(off_cfg[i]);
                if (v < COORD_BOT) begin
                    v = COORD_BOT;
                    sat = 1'b1;
                end else if (v > COORD_TOP) begin
                    v = COORD_TOP;
                    sat = 1'b1;
                end
                if (k == 0) lo_out[i] = v[COORD_W-1:0];
                else hi_out[i] = v[COORD_W-1:0];
            end
        end
        res.out_min_x      = lo_out[0];
        res.out_min_y      = lo_out[1];
        res.out_min_z      = lo_out[2];
        res.out_max_x      = hi_out[0];
        res.out_max_y      = hi_out[1];
        res.out_max_z      = hi_out[2];
        res.saturated_flag = sat;
        clear_box();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        logic [REG_W-1:0] reg_idx;
        t_out_beat        want;
        t_out_beat        fresh;
        if (!i_rst_n) begin
            row_cfg[0] = ROW_X_INIT;
            row_cfg[1] = ROW_Y_INIT;
            row_cfg[2] = ROW_Z_INIT;
            for (int j = 0; j < 3; j++) off_cfg[j] = '0;
            clear_box();
            box_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_idx = paddr[ADDR_W-1:3];
                if (reg_idx <= REG_ROW_Z) row_cfg[reg_idx[1:0]] = pwdata[ROW_W-1:0];
                else if (reg_idx <= REG_OFF_Z)
                    off_cfg[2'(reg_idx - REG_OFF_X)] = pwdata[COORD_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (box_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, i_out);
                    errors++;
                end else begin
                    want = box_q.pop_front();
                    check_field("out_min_x", want.out_min_x, i_out.out_min_x);
                    check_field("out_min_y", want.out_min_y, i_out.out_min_y);
                    check_field("out_min_z", want.out_min_z, i_out.out_min_z);
                    check_field("out_max_x", want.out_max_x, i_out.out_max_x);
                    check_field("out_max_y", want.out_max_y, i_out.out_max_y);
                    check_field("out_max_z", want.out_max_z, i_out.out_max_z);
                    check_field("saturated_flag", COORD_W'(want.saturated_flag),
                                COORD_W'(i_out.saturated_flag));
                end
            end
            if (i_in_valid && !i_in_stall && absorb_point(i_in, fresh)) box_q.push_back(fresh);
        end
        o_pending    <= box_q.size();
        o_fail_count <= errors;
    end

endmodule

/* tb/sv/aabb_accumulate_transform_tb.sv */
module aabb_accumulate_transform_tb;
    import aabb_pkg::*;

    // addresses past the last register: writes there must be dropped
    localparam logic [REG_W-1:0]  REG_SPARE_LO   = 3'd6;
    localparam logic [REG_W-1:0]  REG_SPARE_HI   = 3'd7;
    localparam logic [COEF_W-1:0] COEF_TOP       = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_BOT       = {1'b1, {(COEF_W-1){1'b0}}};
    localparam int                HOLD_CYCLES    = 300;
    localparam int                SEGMENT_POINTS = 150;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in;
    logic              o_out_valid;
    t_out_beat         o_out;
    logic              i_out_stall;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   pending;
    int   fail_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   points_sent;
    logic hold_req;
    logic long_hold;

    aabb_accumulate_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    aabb_transform_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // long output hold while the sender keeps going, to back the block up
    initial begin
        long_hold = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_in_beat pt(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic [COORD_W-1:0] z, input logic last);
        t_in_beat b;
        b.pos_x       = x;
        b.pos_y       = y;
        b.pos_z       = z;
        b.final_point = last;
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] make_row(input logic [COEF_W-1:0] cx,
                                                   input logic [COEF_W-1:0] cy,
                                                   input logic [COEF_W-1:0] cz);
        return DATA_W'({cz, cy, cx});
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3: return COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // coefficient within +-2.0
    function automatic logic [COEF_W-1:0] small_coef();
        return COEF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endfunction

    task automatic send_point(input t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        points_sent++;
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [DATA_W-1:0] rx, input logic [DATA_W-1:0] ry,
                                input logic [DATA_W-1:0] rz, input logic [DATA_W-1:0] ox,
                                input logic [DATA_W-1:0] oy, input logic [DATA_W-1:0] oz);
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_OFF_X, ox);
        write_reg(REG_OFF_Y, oy);
        write_reg(REG_OFF_Z, oz);
    endtask

    // drop valid, let every result drain, then give the pipe time to empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_config();
        case ($urandom_range(0, 4))
            // upper bits of the bus are junk and must be masked off
            0: apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            1, 2: apply_config(make_row(small_coef(), small_coef(), small_coef()),
                               make_row(small_coef(), small_coef(), small_coef()),
                               make_row(small_coef(), small_coef(), small_coef()),
                               DATA_W'(rand_coord()), DATA_W'(rand_coord()),
                               DATA_W'(rand_coord()));
            3: apply_config(make_row(COEF_TOP, COEF_TOP, COEF_TOP),
                            make_row(COEF_TOP, COEF_BOT, COEF_TOP),
                            make_row(COEF_TOP, COEF_TOP, COEF_TOP),
                            DATA_W'(rand_coord()), DATA_W'(rand_coord()),
                            DATA_W'(rand_coord()));
            default: apply_config(make_row(COEF_BOT, COEF_BOT, COEF_BOT),
                                  make_row(COEF_BOT, COEF_BOT, COEF_BOT),
                                  make_row(COEF_BOT, COEF_TOP, COEF_BOT),
                                  DATA_W'(rand_coord()), DATA_W'(rand_coord()),
                                  DATA_W'(rand_coord()));
        endcase
    endtask

    task automatic random_set();
        int n;
        case ($urandom_range(0, 9))
            0: n = 1;
            1, 2: n = $urandom_range(7, 20);
            default: n = $urandom_range(2, 6);
        endcase
        for (int k = 1; k <= n; k++)
            send_point(pt(rand_coord(), rand_coord(), rand_coord(), k == n));
    endtask

    initial begin
        int seg_start;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        points_sent   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity matrix from reset
        send_point(pt(0, 0, 0, 1'b1));
        send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        // lone most-negative point: box high stays at its empty value
        send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        send_point(pt(COORD_MIN, COORD_MAX, 0, 1'b0));
        send_point(pt(COORD_MAX, COORD_MIN, -1, 1'b1));
        // odd sums land on rounding halves
        send_point(pt(0, 0, 0, 1'b0));
        send_point(pt(-1, 1, -1, 1'b1));
        send_point(pt(1, -1, 2, 1'b0));
        send_point(pt(-3, 5, 7, 1'b0));
        send_point(pt(2, 2, -2, 1'b1));
        wait_drained();

        apply_config(make_row(COEF_TOP, COEF_TOP, COEF_TOP), make_row(COEF_TOP, COEF_TOP, COEF_TOP),
                     make_row(COEF_TOP, COEF_TOP, COEF_TOP), DATA_W'(COORD_MAX),
                     DATA_W'(COORD_MAX), DATA_W'(COORD_MAX));
        send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        send_point(pt(5, 5, 5, 1'b1));
        wait_drained();

        apply_config(make_row(COEF_BOT, COEF_BOT, COEF_BOT), make_row(COEF_BOT, COEF_BOT, COEF_BOT),
                     make_row(COEF_BOT, COEF_BOT, COEF_BOT), DATA_W'(COORD_MIN),
                     DATA_W'(COORD_MIN), DATA_W'(COORD_MIN));
        send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        send_point(pt(0, 0, 0, 1'b1));
        wait_drained();

        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_point(pt(3, -3, 7, 1'b1));
        send_point(pt(COORD_MIN, 1, COORD_MAX, 1'b1));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                wait_drained();
                random_config();
                if (phase == 2 && seg == 0) hold_req = 1'b1;
                seg_start = points_sent;
                while (points_sent - seg_start < SEGMENT_POINTS) random_set();
                // sometimes leave a set open across the next register update
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 3))
                        send_point(pt(rand_coord(), rand_coord(), rand_coord(), 1'b0));
            end
        end
        send_point(pt(rand_coord(), rand_coord(), rand_coord(), 1'b1));

        wait_drained();
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* aabb_accumulate_transform.f */
rtl/core/aabb_pkg.sv
rtl/core/aabb_cfg.sv
rtl/core/aabb_box.sv
rtl/core/aabb_xform.sv
rtl/core/aabb_accumulate_transform.sv
tb/sv/aabb_transform_checker.sv
tb/sv/aabb_accumulate_transform_tb.sv
